@@ design/ccdb_pkg.sv @@
// ----------------------------------------------------------------------------
// ccdb_pkg
// Shared types and constants for the channel-mapped CAN double buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ccdb_pkg;

  // number of slots in the channel table and in each frame buffer
  localparam int SLOTS  = 32;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BUF_DEPTH = 2 ** (SLOT_W + 1);

  // item kinds carried in tuser
  localparam logic [2:0] FN_FRAME = 3'd0;
  localparam logic [2:0] FN_TICK  = 3'd1;
  localparam logic [2:0] FN_SWAP  = 3'd2;
  localparam logic [2:0] FN_READ  = 3'd3;
  localparam logic [2:0] FN_MAP   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_VALID_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_CLAMP = 2'd1;

  localparam logic [13:0] VALID_LIMIT_RST   = 14'd500;
  localparam logic [13:0] TIMEOUT_CLAMP_RST = 14'd10000;

  // source code in identifier bits 13..11
  localparam logic [2:0] SRC_CODE = 3'd2;

  // input transaction payload, last field in the lowest bits
  typedef struct packed {
    logic [6:0]  pad;
    logic [10:0] channel;
    logic [5:0]  slot;
    logic [13:0] tick_ms;
    logic [63:0] frame_data;
    logic [3:0]  frame_len;
    logic        frame_ext;
    logic [28:0] frame_id;
  } in_t;

  // result transaction payload, last field in the lowest bits
  typedef struct packed {
    logic [3:0]  pad;
    logic        data_valid;
    logic        stored;
    logic [63:0] out_data;
    logic [3:0]  out_len;
    logic        out_ext;
    logic [28:0] out_id;
  } out_t;

  // one buffer entry
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  len;
    logic        ext;
    logic [28:0] id;
  } buf_word_t;

endpackage

`default_nettype wire

@@ design/can_channel_double_buffer.sv @@
// Flow: an accepted item enters the execute state, where its result is registered
// into the output register once that register is free.
// One item at a time: new items are taken only in the idle state. The frame buffer
// read is issued at accept and a stored frame is written in the execute state.
// Reset: control state, slot-mapped flags and per-entry buffer valid bits clear at
// once; no clearing pass is needed, the block accepts items right after reset.
// ----------------------------------------------------------------------------
// can_channel_double_buffer
// Slot-to-channel table with two frame buffers, a millisecond timeout and
// buffer swap; frames are stored by channel match, slots read back by index.
// ----------------------------------------------------------------------------
`default_nettype none

module can_channel_double_buffer
  import ccdb_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // stream input
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // frame_id, frame_ext, frame_len, frame_data, tick_ms, slot, channel, zero pad
  input  wire logic [135:0] s_axis_tdata,
  // func
  input  wire logic [2:0]   s_axis_tuser,
  // stream output
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_id, out_ext, out_len, out_data, stored, data_valid, zero pad
  output      logic [103:0] m_axis_tdata,
  // configuration write port
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [13:0]  cfg_data_i
);

  typedef enum logic {ST_IDLE, ST_EXEC} state_e;

  state_e      state_q;
  in_t         in_d;
  in_t         in_q;
  logic [2:0]  func_q;
  logic        s_fire;
  logic        done;

  logic [13:0] valid_limit_q;
  logic [13:0] timeout_clamp_q;
  logic [13:0] timeout_q;
  logic [13:0] timeout_d;
  logic        write_side_q;

  logic [10:0]           slot_chan_q [SLOTS];
  logic [SLOTS-1:0]      slot_map_q;
  logic [1:0][SLOTS-1:0] buf_vld_q;

  buf_word_t   buf_mem [BUF_DEPTH];
  buf_word_t   rd_word_q;
  logic [SLOT_W:0] rd_addr;
  logic [SLOT_W:0] wr_addr;
  logic        buf_we;

  logic [10:0]       frame_chan;
  logic              src_ok;
  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  logic [SLOT_W-1:0] slot_idx;
  logic              slot_ok;
  logic [14:0]       tick_sum;

  out_t        out_d;
  out_t        out_q;
  logic        out_valid_q;

  assign in_d          = in_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign done          = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_limit_q   <= VALID_LIMIT_RST;
      timeout_clamp_q <= TIMEOUT_CLAMP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VALID_LIMIT:   valid_limit_q   <= cfg_data_i;
        CFG_TIMEOUT_CLAMP: timeout_clamp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_q   <= in_d;
      func_q <= s_axis_tuser;
    end
  end

  // decode of the captured item
  assign frame_chan = in_q.frame_id[24:14];
  assign src_ok     = (in_q.frame_id[13:11] == SRC_CODE);
  assign slot_idx   = in_q.slot[SLOT_W-1:0];
  assign slot_ok    = ({1'b0, in_q.slot} < 7'(SLOTS));

  // lowest mapped slot whose channel matches
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_map_q[i] && (slot_chan_q[i] == frame_chan)) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
  end

  // next timeout value
  always_comb begin
    tick_sum  = {1'b0, timeout_q} + {1'b0, in_q.tick_ms};
    timeout_d = timeout_q;
    case (func_q)
      FN_FRAME: begin
        if (src_ok) begin
          timeout_d = '0;
        end
      end
      FN_TICK: begin
        if (tick_sum >= {1'b0, timeout_clamp_q}) begin
          timeout_d = timeout_clamp_q;
        end else begin
          timeout_d = tick_sum[13:0];
        end
      end
      default: ;
    endcase
  end

  assign buf_we  = done && (func_q == FN_FRAME) && src_ok && in_q.frame_ext && hit;
  assign wr_addr = {write_side_q, hit_idx};
  assign rd_addr = {~write_side_q, in_d.slot[SLOT_W-1:0]};

  // frame buffer memory, registered read issued at accept
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[wr_addr] <= {in_q.frame_data, in_q.frame_len, in_q.frame_ext, in_q.frame_id};
    end
    if (s_fire) begin
      rd_word_q <= buf_mem[rd_addr];
    end
  end

  // result assembly
  always_comb begin
    out_d            = '0;
    out_d.data_valid = (timeout_d < valid_limit_q);
    out_d.stored     = buf_we;
    if ((func_q == FN_READ) && slot_ok && buf_vld_q[~write_side_q][slot_idx]) begin
      out_d.out_id   = rd_word_q.id;
      out_d.out_ext  = rd_word_q.ext;
      out_d.out_len  = rd_word_q.len;
      out_d.out_data = rd_word_q.data;
    end
  end

  // channel table entries, undefined until mapped
  always_ff @(posedge clk_i) begin
    if (done && (func_q == FN_MAP) && slot_ok) begin
      slot_chan_q[slot_idx] <= in_q.channel;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= out_d;
    end
  end

  // sequencer, state update and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      timeout_q    <= '0;
      write_side_q <= 1'b0;
      slot_map_q   <= '0;
      buf_vld_q    <= '0;
    end else begin
      if (out_valid_q && m_axis_tready && !done) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (done) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            timeout_q   <= timeout_d;
            if (buf_we) begin
              buf_vld_q[write_side_q][hit_idx] <= 1'b1;
            end
            if (func_q == FN_SWAP) begin
              buf_vld_q[~write_side_q] <= '0;
              write_side_q             <= ~write_side_q;
            end
            if ((func_q == FN_MAP) && slot_ok) begin
              slot_map_q[slot_idx] <= 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // one item in flight: an accept is never followed directly by another
  assert property (@(posedge clk_i) disable iff (!rst_ni) s_fire |=> !s_fire)
    else $error("back-to-back accept");

  // a new result only appears after an execute cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("result without execute");

  // a stored frame reports an empty read payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.stored) |-> (out_q.out_id == '0) && (out_q.out_data == '0))
    else $error("store result carries read data");

  // buffer side only flips on a swap item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (write_side_q != $past(write_side_q)) |-> $past(done && (func_q == FN_SWAP)))
    else $error("unexpected buffer swap");
`endif

endmodule

`default_nettype wire

@@ tb/can_channel_double_buffer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_channel_double_buffer_test
// Self-checking stream testbench for the channel-mapped CAN double buffer.
// A built-in predictor tracks the slot table, both frame buffers, the write
// side, the timeout counter and both registers. Every accepted result is
// compared field by field with the oldest predicted result. Stimulus is a
// directed pass, random traffic under several register settings, a long
// output stall and a closing stretch at full rate.
// ----------------------------------------------------------------------------

module can_channel_double_buffer_test;
  import ccdb_pkg::*;

  localparam int          DUT_LATENCY    = 2;
  localparam int          WATCHDOG_LIMIT = 1000;
  localparam int          HOLD_CYCLES    = 80;
  localparam logic [2:0]  FN_TOP         = 3'd7;
  localparam logic [1:0]  CFG_SPARE_A    = 2'd2;
  localparam logic [1:0]  CFG_SPARE_B    = 2'd3;
  localparam logic [13:0] W14_MAX        = 14'h3FFF;
  localparam int          TICK_MAX       = 10000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // frame_id, frame_ext, frame_len, frame_data, tick_ms, slot, channel, zero pad
  logic [135:0] s_axis_tdata = '0;
  // func
  logic [2:0]   s_axis_tuser = FN_FRAME;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // out_id, out_ext, out_len, out_data, stored, data_valid, zero pad
  logic [103:0] m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = CFG_VALID_LIMIT;
  logic [13:0]  cfg_data_i = '0;

  // predicted block state
  logic [13:0] m_limit = VALID_LIMIT_RST;
  logic [13:0] m_clamp = TIMEOUT_CLAMP_RST;
  logic [10:0] m_chan [SLOTS];
  bit          m_mapped [SLOTS] = '{default: 1'b0};
  buf_word_t   m_buf [2*SLOTS] = '{default: '0};
  bit          m_side = 1'b0;
  logic [13:0] m_tmo = '0;

  out_t expected_readback_q [$];
  int   mismatch_count = 0;
  int   stall_cycles = 0;
  bit   src_idle_en = 1'b1;
  bit   sink_idle_en = 1'b1;
  bit   hold_req = 1'b0;

  can_channel_double_buffer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor: apply one item to the tracked state, return its result
  function automatic out_t step_buffers(logic [2:0] fn, in_t it);
    out_t        r;
    int unsigned sum;
    logic [10:0] fch;
    int          i;
    int          base;
    r = '0;
    case (fn)
      FN_FRAME: begin
        if (it.frame_id[13:11] == SRC_CODE) begin
          m_tmo = '0;
          if (it.frame_ext) begin
            fch = it.frame_id[24:14];
            for (i = 0; i < SLOTS; i++) begin
              if (!r.stored && m_mapped[i] && m_chan[i] == fch) begin
                m_buf[m_side*SLOTS + i] = '{data: it.frame_data, len: it.frame_len,
                                           ext: it.frame_ext, id: it.frame_id};
                r.stored = 1'b1;
              end
            end
          end
        end
      end
      FN_TICK: begin
        sum = m_tmo + it.tick_ms;
        if (sum >= m_clamp) sum = m_clamp;
        m_tmo = sum[13:0];
      end
      FN_SWAP: begin
        base = (!m_side) * SLOTS;
        for (i = 0; i < SLOTS; i++) m_buf[base + i] = '0;
        m_side = !m_side;
      end
      FN_READ: begin
        if (it.slot < SLOTS) begin
          base = (!m_side) * SLOTS + it.slot;
          r.out_id   = m_buf[base].id;
          r.out_ext  = m_buf[base].ext;
          r.out_len  = m_buf[base].len;
          r.out_data = m_buf[base].data;
        end
      end
      FN_MAP: begin
        if (it.slot < SLOTS) begin
          m_chan[it.slot]   = it.channel;
          m_mapped[it.slot] = 1'b1;
        end
      end
      default: ;
    endcase
    r.data_valid = (m_tmo < m_limit);
    return r;
  endfunction

  function automatic in_t make_frame(logic [28:0] fill, logic [2:0] src, logic [10:0] chan,
                                     logic ext, logic [3:0] len, logic [63:0] data);
    in_t it;
    it = '0;
    it.frame_id        = fill;
    it.frame_id[13:11] = src;
    it.frame_id[24:14] = chan;
    it.frame_ext       = ext;
    it.frame_len       = len;
    it.frame_data      = data;
    return it;
  endfunction

  function automatic in_t make_ctl(logic [13:0] tick, logic [5:0] slot, logic [10:0] chan);
    in_t it;
    it = '0;
    it.tick_ms = tick;
    it.slot    = slot;
    it.channel = chan;
    return it;
  endfunction

  // channel that some mapped slot holds, or a random one if none is mapped
  function automatic logic [10:0] pick_channel();
    int i;
    int s;
    s = $urandom_range(0, SLOTS - 1);
    if (m_mapped[s]) return m_chan[s];
    for (i = 0; i < SLOTS; i++) if (m_mapped[i]) return m_chan[i];
    return 11'($urandom_range(0, 2047));
  endfunction

  // one random item, weighted toward frames that hit the table
  task automatic pick_item(output logic [2:0] fn, output in_t it);
    int roll;
    roll = $urandom_range(0, 99);
    it = '0;
    if (roll < 35) begin
      fn = FN_FRAME;
      it = make_frame(29'($urandom), SRC_CODE, pick_channel(), 1'b1,
                      4'($urandom_range(0, 8)), {$urandom, $urandom});
    end else if (roll < 45) begin
      fn = FN_FRAME;
      it.frame_id   = 29'($urandom);
      it.frame_ext  = 1'($urandom);
      it.frame_len  = 4'($urandom_range(0, 8));
      it.frame_data = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 0) it.frame_id[13:11] = SRC_CODE;
    end else if (roll < 60) begin
      fn = FN_TICK;
      if ($urandom_range(0, 3) != 0) it.tick_ms = 14'($urandom_range(0, 200));
      else it.tick_ms = 14'($urandom_range(0, TICK_MAX));
    end else if (roll < 68) begin
      fn = FN_SWAP;
    end else if (roll < 88) begin
      fn = FN_READ;
      if ($urandom_range(0, 6) != 0) it.slot = 6'($urandom_range(0, SLOTS - 1));
      else it.slot = 6'($urandom_range(SLOTS, 63));
    end else if (roll < 96) begin
      fn = FN_MAP;
      if ($urandom_range(0, 9) != 0) it.slot = 6'($urandom_range(0, SLOTS - 1));
      else it.slot = 6'($urandom_range(SLOTS, 63));
      if ($urandom_range(0, 1) == 0) it.channel = pick_channel();
      else it.channel = 11'($urandom_range(0, 2047));
    end else begin
      fn = 3'($urandom_range(FN_MAP + 1, FN_TOP));
    end
    // fields the item kind ignores still carry random bits
    if (fn != FN_TICK) it.tick_ms = 14'($urandom_range(0, TICK_MAX));
    if (fn != FN_READ && fn != FN_MAP) begin
      it.slot    = 6'($urandom);
      it.channel = 11'($urandom);
    end
    if (fn != FN_FRAME) begin
      it.frame_id   = 29'($urandom);
      it.frame_ext  = 1'($urandom);
      it.frame_len  = 4'($urandom_range(0, 8));
      it.frame_data = {$urandom, $urandom};
    end
  endtask

  // offer one transaction and record its predicted result on acceptance
  task automatic send_item(input logic [2:0] fn, input in_t it);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    s_axis_tuser  <= fn;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_readback_q.push_back(step_buffers(fn, it));
  endtask

  task automatic send_random(input int count);
    logic [2:0] fn;
    in_t        it;
    repeat (count) begin
      pick_item(fn, it);
      send_item(fn, it);
    end
  endtask

  // stop offering and let every pending result come out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_readback_q.size() != 0) @(posedge clk_i);
    repeat (DUT_LATENCY + 1) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [13:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_VALID_LIMIT:   m_limit = val;
      CFG_TIMEOUT_CLAMP: m_clamp = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // table extremes, every item kind and the corner cases
  task automatic test_directed_cases();
    send_item(FN_READ, make_ctl('0, 6'd0, '0));
    send_item(FN_MAP, make_ctl('0, 6'd0, 11'd0));
    send_item(FN_MAP, make_ctl('0, 6'd31, 11'd2047));
    // same channel in a lower slot: the lower slot wins
    send_item(FN_MAP, make_ctl('0, 6'd5, 11'd2047));
    // out-of-range slots are ignored
    send_item(FN_MAP, make_ctl('0, 6'd63, 11'd1234));
    send_item(FN_MAP, make_ctl('0, 6'd32, 11'd100));
    send_item(FN_FRAME, make_frame('1, SRC_CODE, 11'd2047, 1'b1, 4'd8, '1));
    send_item(FN_FRAME, make_frame('0, SRC_CODE, 11'd0, 1'b1, 4'd0, '0));
    // standard frame from the source only clears the timeout
    send_item(FN_TICK, make_ctl(14'd300, '0, '0));
    send_item(FN_FRAME, make_frame('1, SRC_CODE, 11'd0, 1'b0, 4'd3, 64'h1234));
    // other source, then a channel with no slot
    send_item(FN_TICK, make_ctl(14'd700, '0, '0));
    send_item(FN_FRAME, make_frame('1, 3'd7, 11'd2047, 1'b1, 4'd8, '1));
    send_item(FN_FRAME, make_frame('0, SRC_CODE, 11'd100, 1'b1, 4'd2, 64'h55));
    // counter saturation at the clamp
    send_item(FN_TICK, make_ctl(14'(TICK_MAX), '0, '0));
    send_item(FN_TICK, make_ctl(14'(TICK_MAX), '0, '0));
    send_item(FN_TICK, make_ctl('0, '0, '0));
    // frames sit in the write side until a swap
    send_item(FN_READ, make_ctl('0, 6'd5, '0));
    send_item(FN_SWAP, make_ctl('0, '0, '0));
    send_item(FN_READ, make_ctl('0, 6'd5, '0));
    send_item(FN_READ, make_ctl('0, 6'd0, '0));
    send_item(FN_READ, make_ctl('0, 6'd31, '0));
    send_item(FN_READ, make_ctl('0, 6'd63, '0));
    send_item(FN_TOP, make_ctl('1, '1, '1));
    send_item(FN_MAP + 1, make_ctl('1, 6'd1, 11'd7));
    send_item(FN_SWAP, make_ctl('0, '0, '0));
    send_item(FN_READ, make_ctl('0, 6'd5, '0));
    wait_idle();
  endtask

  // random traffic under a range of register settings
  task automatic test_config_settings();
    logic [13:0] limits [7];
    logic [13:0] clamps [7];
    int          p;
    limits = '{'0, W14_MAX, W14_MAX, '0, 14'd50, 14'($urandom), VALID_LIMIT_RST};
    clamps = '{'0, W14_MAX, '0, W14_MAX, 14'd120, 14'($urandom), TIMEOUT_CLAMP_RST};
    // unused indexes must not disturb either register
    write_reg(CFG_SPARE_A, 14'd1);
    write_reg(CFG_SPARE_B, W14_MAX);
    for (p = 0; p < 7; p++) begin
      write_reg(CFG_VALID_LIMIT, limits[p]);
      write_reg(CFG_TIMEOUT_CLAMP, clamps[p]);
      send_random(130);
      wait_idle();
    end
  endtask

  // long output stall while items keep coming
  task automatic test_output_backpressure();
    src_idle_en = 1'b0;
    hold_req    = 1'b1;
    send_random(40);
    wait_idle();
    src_idle_en = 1'b1;
  endtask

  task automatic test_full_rate();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    send_random(120);
    wait_idle();
  endtask

  // stimulus
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_config_settings();
    test_output_backpressure();
    test_full_rate();
    if (mismatch_count == 0) begin
      $display("can_channel_double_buffer_test: PASS");
    end else begin
      $display("can_channel_double_buffer_test: FAIL");
    end
    $finish;
  end

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : check_results
    out_t want;
    out_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_readback_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = expected_readback_q.pop_front();
        check_field("out_id", want.out_id, got.out_id);
        check_field("out_ext", want.out_ext, got.out_ext);
        check_field("out_len", want.out_len, got.out_len);
        check_field("out_data", want.out_data, got.out_data);
        check_field("stored", want.stored, got.stored);
        check_field("data_valid", want.data_valid, got.data_valid);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
      $display("can_channel_double_buffer_test: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
